>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge while reset is released.
`define TCGL_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("tcgl assertion failed");

// Check prop at every rising edge, reset included.
`define TCGL_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tcgl assertion failed");

`endif

>>> src/tcgl_pkg.sv
`default_nettype none

package tcgl_pkg;

	// Action codes carried on tuser; the fourth code is ignored.
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_CHAR  = 2'd2;

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

	typedef enum logic [2:0] {
		REG_SPACE_SIZE     = 3'd0,
		REG_SPACE_EXTRA    = 3'd1,
		REG_LETTER_SPACING = 3'd2,
		REG_LINE_SPACING   = 3'd3,
		REG_LINE_ADVANCE   = 3'd4,
		REG_LINE_HEIGHT    = 3'd5,
		REG_SCALE          = 3'd6
	} reg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int IN_DATA_W  = 48;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 64;

	typedef struct packed {
		logic [7:0]        space_size;
		logic signed [7:0] space_extra;
		logic signed [7:0] letter_spacing;
		logic signed [7:0] line_spacing;
		logic [7:0]        line_advance;
		logic [7:0]        line_height;
		logic [11:0]       scale;
	} cfg_t;

	// One accepted item after the input register, with its table width.
	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         code;
		logic [7:0]         width;
		logic               code_oor;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
	} item_t;

	// pos + delta*scale/256, truncated toward zero, clamped to 16 bits signed.
	function automatic logic signed [15:0] move_pos(input logic signed [15:0] pos,
			input logic signed [9:0] delta, input logic [11:0] scale);
		logic signed [22:0] d_ext;
		logic signed [22:0] s_ext;
		logic signed [22:0] prod;
		logic signed [24:0] sum;
		logic signed [16:0] q;
		logic signed [17:0] r;
		logic               fix;
		d_ext = 23'(delta);
		s_ext = 23'($signed({1'b0, scale}));
		prod  = d_ext * s_ext;
		sum   = $signed({pos[15], pos, 8'h00}) + 25'(prod);
		q     = sum[24:8];
		fix   = sum[24] && (|sum[7:0]);
		r     = 18'(q) + {17'b0, fix};
		if (r > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (r < -18'sd32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

endpackage

`default_nettype wire

>>> src/tcgl_front.sv
`default_nettype none

module tcgl_front #(
	parameter int GLYPH_COUNT = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [tcgl_pkg::IN_DATA_W-1:0] s_axis_tdata,
	input  wire logic [tcgl_pkg::IN_USER_W-1:0] s_axis_tuser,
	output tcgl_pkg::item_t                  item_s1,
	output logic                             valid_s1,
	input  wire logic                        take
);
	import tcgl_pkg::*;

	localparam int IdxW = $clog2(GLYPH_COUNT);

	logic [7:0]      width_mem [GLYPH_COUNT];
	logic            accept;
	logic [7:0]      in_code;
	logic            in_range;
	logic [IdxW-1:0] idx;

	assign s_axis_tready = !valid_s1 || take;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_code       = s_axis_tdata[7:0];
	assign in_range      = {1'b0, in_code} < 9'(GLYPH_COUNT);
	assign idx           = in_code[IdxW-1:0];

	// Loads write on the accept edge, so a glyph right behind reads the new width.
	always_ff @(posedge clk) begin
		if (accept && s_axis_tuser == ACT_LOAD && in_range) begin
			width_mem[idx] <= s_axis_tdata[15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action   <= s_axis_tuser;
			item_s1.code     <= in_code;
			item_s1.width    <= width_mem[idx];
			item_s1.code_oor <= !in_range;
			item_s1.start_x  <= s_axis_tdata[31:16];
			item_s1.start_y  <= s_axis_tdata[47:32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

endmodule

`default_nettype wire

>>> src/tcgl_core.sv
`default_nettype none

module tcgl_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire tcgl_pkg::cfg_t               cfg,
	input  wire tcgl_pkg::item_t              item_s1,
	input  wire logic                         valid_s1,
	output logic                              take,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [tcgl_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import tcgl_pkg::*;

	logic signed [15:0] cursor_x_q;
	logic signed [15:0] cursor_y_q;
	logic signed [15:0] origin_x_q;
	logic               is_space;
	logic               is_newline;
	logic               emits;
	logic [7:0]         w;
	logic signed [9:0]  delta;
	logic signed [15:0] pos;
	logic signed [15:0] moved;
	logic [19:0]        w_prod;
	logic [19:0]        h_prod;

	assign is_space   = item_s1.code == CHAR_SPACE;
	assign is_newline = item_s1.code == CHAR_NEWLINE;
	assign emits      = item_s1.action == ACT_CHAR && !is_space && !is_newline;
	// Items without a result never wait on the output side.
	assign take       = valid_s1 && (!emits || !m_axis_tvalid || m_axis_tready);
	assign w          = item_s1.code_oor ? 8'h00 : item_s1.width;

	always_comb begin
		if (is_space) begin
			delta = $signed({2'b00, cfg.space_size}) + 10'(cfg.space_extra);
			pos   = cursor_x_q;
		end else if (is_newline) begin
			delta = -($signed({2'b00, cfg.line_advance}) + 10'(cfg.line_spacing));
			pos   = cursor_y_q;
		end else begin
			delta = $signed({2'b00, w}) + 10'(cfg.letter_spacing);
			pos   = cursor_x_q;
		end
	end

	assign moved  = move_pos(pos, delta, cfg.scale);
	assign w_prod = {12'b0, w} * {8'b0, cfg.scale};
	assign h_prod = {12'b0, cfg.line_height} * {8'b0, cfg.scale};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			origin_x_q <= '0;
		end else if (take) begin
			case (item_s1.action)
				ACT_START: begin
					origin_x_q <= item_s1.start_x;
					cursor_x_q <= item_s1.start_x;
					cursor_y_q <= item_s1.start_y;
				end
				ACT_CHAR: begin
					if (is_newline) begin
						cursor_x_q <= origin_x_q;
						cursor_y_q <= moved;
					end else begin
						cursor_x_q <= moved;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (take && emits) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emits) begin
			m_axis_tdata <= {item_s1.code, h_prod[19:8], w_prod[19:8],
				cursor_y_q, cursor_x_q};
		end
	end

endmodule

`default_nettype wire

>>> src/text_cursor_glyph_layout_unit.sv
`default_nettype none
// Channel      Dir  Beat fields
// s_axis       in   tdata: char_code, width_value, start_x, start_y; tuser: action
// m_axis       out  tdata: rect_x, rect_y, rect_width, rect_height, glyph
// cfg          in   cfg_we, cfg_index, cfg_data; write only
//
// One beat per cycle in, one rectangle per cycle out, unless m_axis stalls.
// The width table read is registered, so the input register holds the width.
// The cursor update (one multiply-add and clamp) is done in the result stage.
// Load, start, space and newline beats pass without waiting on m_axis_tready.
// Reset clears cursor, origin, valid flags; config gets defaults, table is kept.

module text_cursor_glyph_layout_unit #(
	parameter int GLYPH_COUNT = 256
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// char_code[7:0], width_value[15:8], start_x[31:16], start_y[47:32]
	input  wire logic [tcgl_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// action[1:0]
	input  wire logic [tcgl_pkg::IN_USER_W-1:0] s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// rect_x[15:0], rect_y[31:16], rect_width[43:32], rect_height[55:44], glyph[63:56]
	output logic [tcgl_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [tcgl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tcgl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tcgl_pkg::*;

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.space_size     <= 8'd8;
			cfg_q.space_extra    <= 8'sd0;
			cfg_q.letter_spacing <= 8'sd5;
			cfg_q.line_spacing   <= 8'sd5;
			cfg_q.line_advance   <= 8'd16;
			cfg_q.line_height    <= 8'd16;
			cfg_q.scale          <= 12'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPACE_SIZE:     cfg_q.space_size     <= cfg_data[7:0];
				REG_SPACE_EXTRA:    cfg_q.space_extra    <= cfg_data[7:0];
				REG_LETTER_SPACING: cfg_q.letter_spacing <= cfg_data[7:0];
				REG_LINE_SPACING:   cfg_q.line_spacing   <= cfg_data[7:0];
				REG_LINE_ADVANCE:   cfg_q.line_advance   <= cfg_data[7:0];
				REG_LINE_HEIGHT:    cfg_q.line_height    <= cfg_data[7:0];
				REG_SCALE:          cfg_q.scale          <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tcgl_front #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.item_s1      (item_s1),
		.valid_s1     (valid_s1),
		.take         (take)
	);

	tcgl_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.item_s1      (item_s1),
		.valid_s1     (valid_s1),
		.take         (take),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

`default_nettype wire

>>> src/tcgl_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tcgl_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_axis_tready,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [tcgl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import tcgl_pkg::*;

	// Hold a stalled result beat.
	`TCGL_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
	`TCGL_ASSERT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
	// An empty result register never blocks the input.
	`TCGL_ASSERT_ALWAYS(a_ready_when_empty, clk, !m_axis_tvalid |-> s_axis_tready)
	// Spaces and newlines only move the cursor.
	`TCGL_ASSERT(a_glyph_drawable, clk, arst_n, m_axis_tvalid |-> m_axis_tdata[63:56] != CHAR_SPACE && m_axis_tdata[63:56] != CHAR_NEWLINE)
	`TCGL_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !m_axis_tvalid)

endmodule

bind text_cursor_glyph_layout_unit tcgl_checker u_tcgl_checker (.*);

`default_nettype wire
